### rtl/core/bg_mosaic_and_layer_compositor_assert.svh
// Assertion macros for the background mosaic and layer compositor.
// Used by the top level only; the macros need i_clk and i_rst_n in scope.
`ifndef BG_MOSAIC_AND_LAYER_COMPOSITOR_ASSERT_SVH
`define BG_MOSAIC_AND_LAYER_COMPOSITOR_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define BGMC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");
// Next-cycle implication, checked outside reset.
`define BGMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");
`else
`define BGMC_ASSERT_IMP(label, ante, cons)
`define BGMC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/core/bgmc_pkg.sv
// Shared types and constants for the background mosaic and layer compositor.
// No dependencies; every module in rtl/core imports it.
`timescale 1ns / 1ps

package bgmc_pkg;

    // Default geometry
    localparam int BGMC_LINE_WIDTH   = 240;
    localparam int BGMC_LAYER_COUNT  = 4;
    localparam int BGMC_MAX_LAYERS   = 4;
    localparam int BGMC_SPRITE_PRIOS = 4;

    // Color with bit 15 set is transparent
    typedef logic [15:0] t_color;
    localparam t_color COLOR_CLEAR = 16'h8000;

    // ceil(2^16 / m) for block size m = 1..16; exact floor division for 8-bit values
    localparam int RECIP_SHIFT = 16;
    localparam logic [16:0] MOS_RECIP [16] = '{
        17'd65536, 17'd32768, 17'd21846, 17'd16384,
        17'd13108, 17'd10923, 17'd9363,  17'd8192,
        17'd7282,  17'd6554,  17'd5958,  17'd5462,
        17'd5042,  17'd4682,  17'd4370,  17'd4096
    };

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_LAYER_ENABLE = 3'd0,
        CFG_LAYER_PRIO   = 3'd1,
        CFG_SPRITES_ON   = 3'd2,
        CFG_BACKDROP     = 3'd3,
        CFG_MOSAIC_W     = 3'd4,
        CFG_MOSAIC_H     = 3'd5,
        CFG_LAYER_MOSAIC = 3'd6
    } t_cfg_idx;

    // Per-pixel control handed to every layer lane
    typedef struct packed {
        logic adv;       // pixel in the mosaic stage leaves this cycle
        logic v_sample;  // line is a vertical mosaic sample
        logic h_sample;  // column is a horizontal mosaic sample
        logic in_line;   // column lies inside the line store
        logic clr;       // line store clearing pass running
    } t_lane_ctl;

endpackage

### rtl/core/bg_mosaic_and_layer_compositor.sv
// Path: a pixel passes through the input register, the stage-two register and the output register.
// Throughput: one pixel per cycle; the pipeline stalls only when the output is not taken.
// Stages: input register, mosaic phase and line-store read, lane mosaic and merge, output.
// Reset: synchronous active low; configuration clears to zero, held colors to transparent.
// After reset a clearing pass fills every line-store entry with transparent;
// no pixel is accepted during it, configuration words are.
`timescale 1ns / 1ps
`include "bg_mosaic_and_layer_compositor_assert.svh"

module bg_mosaic_and_layer_compositor import bgmc_pkg::*; #(
    parameter int LINE_WIDTH  = BGMC_LINE_WIDTH,
    parameter int LAYER_COUNT = BGMC_LAYER_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data,
    // pixel input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_line_number,
    input  logic [7:0]  i_column,
    input  logic [15:0] i_layer0_color,
    input  logic [15:0] i_layer1_color,
    input  logic [15:0] i_layer2_color,
    input  logic [15:0] i_layer3_color,
    input  logic [15:0] i_sprite_prio0_color,
    input  logic [15:0] i_sprite_prio1_color,
    input  logic [15:0] i_sprite_prio2_color,
    input  logic [15:0] i_sprite_prio3_color,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [14:0] o_screen_color
);

    localparam int AW = $clog2(LINE_WIDTH);
    localparam int CW = (AW > 8) ? AW : 8;
    localparam logic [AW-1:0] CLR_LAST = AW'(LINE_WIDTH - 1);

    // configuration registers
    logic [3:0]  r_layer_en;
    logic [7:0]  r_layer_prio;
    logic        r_sprites_on;
    logic [14:0] r_backdrop;
    logic [3:0]  r_mos_w;
    logic [3:0]  r_mos_h;
    logic [3:0]  r_layer_mos;

    // clearing pass
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // pipeline
    logic          r_s1_v;
    logic [7:0]    r_s1_line;
    logic [7:0]    r_s1_col;
    t_color        r_s1_layer  [BGMC_MAX_LAYERS];
    t_color        r_s1_sprite [BGMC_SPRITE_PRIOS];
    logic          r_s2_v;
    logic [AW-1:0] r_s2_addr;
    logic          r_s2_inline;
    t_color        r_s2_layer  [BGMC_MAX_LAYERS];
    t_color        r_s2_sprite [BGMC_SPRITE_PRIOS];
    logic          r_out_v;

    logic          adv1;
    logic          adv2;
    logic          s2_go;
    logic          in_go;
    logic [CW:0]   s1_col_ext;
    logic          s1_inline;
    logic [AW-1:0] s1_addr;
    logic          line_zero;
    logic          col_zero;
    t_lane_ctl     lane_ctl;
    t_color        in_layer  [BGMC_MAX_LAYERS];
    t_color        in_sprite [BGMC_SPRITE_PRIOS];
    t_color        post_color [BGMC_MAX_LAYERS];

    // Handshakes and stage advance
    assign adv2        = !r_out_v || i_out_ready;
    assign adv1        = !r_s2_v || adv2;
    assign s2_go       = r_s2_v && adv2;
    assign o_in_ready  = !r_clr_busy && (!r_s1_v || adv1);
    assign in_go       = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_v;
    assign o_cfg_ready = 1'b1;

    assign in_layer  = '{i_layer0_color, i_layer1_color, i_layer2_color, i_layer3_color};
    assign in_sprite = '{i_sprite_prio0_color, i_sprite_prio1_color,
                         i_sprite_prio2_color, i_sprite_prio3_color};

    // Take configuration words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_en   <= '0;
            r_layer_prio <= '0;
            r_sprites_on <= 1'b0;
            r_backdrop   <= '0;
            r_mos_w      <= '0;
            r_mos_h      <= '0;
            r_layer_mos  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LAYER_ENABLE: r_layer_en   <= i_cfg_data[3:0];
                CFG_LAYER_PRIO:   r_layer_prio <= i_cfg_data[7:0];
                CFG_SPRITES_ON:   r_sprites_on <= i_cfg_data[0];
                CFG_BACKDROP:     r_backdrop   <= i_cfg_data;
                CFG_MOSAIC_W:     r_mos_w      <= i_cfg_data[3:0];
                CFG_MOSAIC_H:     r_mos_h      <= i_cfg_data[3:0];
                CFG_LAYER_MOSAIC: r_layer_mos  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Sweep the line store once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == CLR_LAST) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (in_go) begin
                r_s1_v <= 1'b1;
            end else if (adv1) begin
                r_s1_v <= 1'b0;
            end
            if (adv1) begin
                r_s2_v <= r_s1_v;
            end
            if (adv2) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    // Column position against the line store
    assign s1_col_ext = (CW+1)'(r_s1_col);
    assign s1_inline  = s1_col_ext < (CW+1)'(LINE_WIDTH);
    assign s1_addr    = s1_col_ext[AW-1:0];

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_s1_line   <= i_line_number;
            r_s1_col    <= i_column;
            r_s1_layer  <= in_layer;
            r_s1_sprite <= in_sprite;
        end
        if (adv1) begin
            r_s2_addr   <= s1_addr;
            r_s2_inline <= s1_inline;
            r_s2_layer  <= r_s1_layer;
            r_s2_sprite <= r_s1_sprite;
        end
    end

    // Mosaic phases of line and column
    bgmc_phase u_line_phase (
        .i_clk     (i_clk),
        .i_adv     (adv1),
        .i_value   (r_s1_line),
        .i_size_m1 (r_mos_h),
        .o_zero    (line_zero)
    );

    bgmc_phase u_col_phase (
        .i_clk     (i_clk),
        .i_adv     (adv1),
        .i_value   (r_s1_col),
        .i_size_m1 (r_mos_w),
        .o_zero    (col_zero)
    );

    assign lane_ctl = '{adv:      s2_go,
                        v_sample: line_zero,
                        h_sample: col_zero,
                        in_line:  r_s2_inline,
                        clr:      r_clr_busy};

    // One lane per present layer; absent layers read as transparent
    for (genvar n = 0; n < BGMC_MAX_LAYERS; n++) begin : g_lane
        if (n < LAYER_COUNT) begin : g_on
            bgmc_lane #(
                .LINE_WIDTH (LINE_WIDTH)
            ) u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (lane_ctl),
                .i_mos      (r_layer_en[n] & r_layer_mos[n]),
                .i_rd_en    (adv1),
                .i_rd_addr  (s1_addr),
                .i_wr_addr  (r_s2_addr),
                .i_clr_addr (r_clr_addr),
                .i_color    (r_s2_layer[n]),
                .o_color    (post_color[n])
            );
        end else begin : g_off
            assign post_color[n] = COLOR_CLEAR;
        end
    end

    // Merge lanes and sprites into the output register
    bgmc_merge u_merge (
        .i_clk          (i_clk),
        .i_load         (adv2),
        .i_layer_color  (post_color),
        .i_sprite_color (r_s2_sprite),
        .i_layer_enable (r_layer_en),
        .i_layer_prio   (r_layer_prio),
        .i_sprites_on   (r_sprites_on),
        .i_backdrop     (r_backdrop),
        .o_color        (o_screen_color)
    );

    // Checks
    `BGMC_ASSERT_IMP(a_clr_blocks_input, r_clr_busy, !o_in_ready)
    `BGMC_ASSERT_IMP(a_clr_full_sweep, $fell(r_clr_busy), $past(r_clr_addr) == CLR_LAST)
    `BGMC_ASSERT_NEXT(a_s2_reaches_out, r_s2_v && adv2, r_out_v)
    `BGMC_ASSERT_NEXT(a_s2_holds_on_stall, r_s2_v && !adv2, r_s2_v)

endmodule

### rtl/core/bgmc_phase.sv
// Mosaic phase unit: tells whether an 8-bit value is a multiple of the block size.
// Reciprocal multiply, register, back-multiply and compare. Depends on bgmc_pkg.
`timescale 1ns / 1ps

module bgmc_phase import bgmc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_adv,
    input  logic [7:0] i_value,
    input  logic [3:0] i_size_m1,
    output logic       o_zero
);

    logic [24:0] prod;
    logic [7:0]  r_value;
    logic [7:0]  r_quot;
    logic [12:0] back;

    // Quotient by reciprocal multiply
    assign prod = 25'(i_value) * 25'(MOS_RECIP[i_size_m1]);

    // Hold value and quotient for the next stage
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_value <= i_value;
            r_quot  <= prod[RECIP_SHIFT+7:RECIP_SHIFT];
        end
    end

    // Remainder is zero when quotient times size gives the value back
    assign back   = 13'(r_quot) * 13'({1'b0, i_size_m1} + 5'd1);
    assign o_zero = (back == 13'(r_value));

endmodule

### rtl/core/bgmc_lane.sv
// One background layer lane: mosaic hold, previous-line store and its bypass.
// Depends on bgmc_pkg; instantiated once per layer by the top level.
`timescale 1ns / 1ps

module bgmc_lane import bgmc_pkg::*; #(
    parameter  int LINE_WIDTH = BGMC_LINE_WIDTH,
    localparam int AW         = $clog2(LINE_WIDTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_lane_ctl     i_ctl,
    input  logic          i_mos,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [AW-1:0] i_clr_addr,
    input  t_color        i_color,
    output t_color        o_color
);

    t_color        mem [LINE_WIDTH];
    t_color        r_rd_data;
    t_color        r_byp_data;
    logic          r_byp_v;
    t_color        r_held;
    t_color        prev;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_color        wr_data;

    // Write port: clearing pass or the departing pixel
    assign wr_en   = i_ctl.clr | (i_ctl.adv & i_ctl.in_line);
    assign wr_addr = i_ctl.clr ? i_clr_addr : i_wr_addr;
    assign wr_data = i_ctl.clr ? COLOR_CLEAR : o_color;

    // Line store with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= mem[i_rd_addr];
            r_byp_data <= wr_data;
        end
    end

    // Flag a read that collides with the write in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_v <= 1'b0;
        end else if (i_rd_en) begin
            r_byp_v <= wr_en && (wr_addr == i_rd_addr);
        end
    end

    // Capture a new held color at each sample point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= COLOR_CLEAR;
        end else if (i_ctl.adv && i_mos && i_ctl.v_sample && i_ctl.h_sample) begin
            r_held <= i_color;
        end
    end

    assign prev = r_byp_v ? r_byp_data : r_rd_data;

    // Select the post-mosaic color
    always_comb begin
        o_color = i_color;
        if (i_mos) begin
            if (i_ctl.v_sample) begin
                o_color = i_ctl.h_sample ? i_color : r_held;
            end else begin
                o_color = i_ctl.in_line ? prev : COLOR_CLEAR;
            end
        end
    end

endmodule

### rtl/core/bgmc_merge.sv
// Priority merge of the layer lanes and sprite colors into one screen color.
// Registers the result; depends on bgmc_pkg.
`timescale 1ns / 1ps

module bgmc_merge import bgmc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_load,
    input  t_color      i_layer_color  [BGMC_MAX_LAYERS],
    input  t_color      i_sprite_color [BGMC_SPRITE_PRIOS],
    input  logic [3:0]  i_layer_enable,
    input  logic [7:0]  i_layer_prio,
    input  logic        i_sprites_on,
    input  logic [14:0] i_backdrop,
    output logic [14:0] o_color
);

    logic [14:0] pick;

    // Walk from the lowest rank up so the best candidate is written last
    always_comb begin
        pick = i_backdrop;
        for (int p = BGMC_SPRITE_PRIOS - 1; p >= 0; p--) begin
            for (int n = BGMC_MAX_LAYERS - 1; n >= 0; n--) begin
                if (i_layer_enable[n] && (i_layer_prio[2*n +: 2] == 2'(p)) &&
                    !i_layer_color[n][15]) begin
                    pick = i_layer_color[n][14:0];
                end
            end
            if (i_sprites_on && !i_sprite_color[p][15]) begin
                pick = i_sprite_color[p][14:0];
            end
        end
    end

    // Hold the result for the output side
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_color <= pick;
        end
    end

endmodule

### test/testbench.sv
// Self-checking testbench for bg_mosaic_and_layer_compositor: mosaic, line store and priority.
// Depends on bgmc_pkg and the compositor RTL; a built-in predictor checks each screen color.
`timescale 1ns / 1ps

module testbench;
    import bgmc_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    // One screen pixel as it is presented on the input channel
    typedef struct packed {
        logic [7:0]   line;
        logic [7:0]   column;
        t_color [3:0] bg;
        t_color [3:0] spr;
    } t_pixel;

    // Register file image
    typedef struct packed {
        logic [3:0]  layer_en;
        logic [7:0]  prio;
        logic        sprites;
        logic [14:0] backdrop;
        logic [3:0]  mos_w;
        logic [3:0]  mos_h;
        logic [3:0]  mos_en;
    } t_regs;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [14:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_line_number = '0;
    logic [7:0]  i_column = '0;
    logic [15:0] i_layer0_color = '0;
    logic [15:0] i_layer1_color = '0;
    logic [15:0] i_layer2_color = '0;
    logic [15:0] i_layer3_color = '0;
    logic [15:0] i_sprite_prio0_color = '0;
    logic [15:0] i_sprite_prio1_color = '0;
    logic [15:0] i_sprite_prio2_color = '0;
    logic [15:0] i_sprite_prio3_color = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [14:0] o_screen_color;

    // Predictor state
    t_regs       live_cfg;
    t_color      line_store [BGMC_LAYER_COUNT][BGMC_LINE_WIDTH];
    t_color      held_colors [BGMC_LAYER_COUNT];
    logic [14:0] pending_colors [$];

    int unsigned mismatch_count = 0;
    int unsigned src_gap_pct = 0;
    logic        sink_stalls = 1'b0;
    int unsigned hold_left = 0;
    logic [14:0] want;

    bg_mosaic_and_layer_compositor dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_line_number        (i_line_number),
        .i_column             (i_column),
        .i_layer0_color       (i_layer0_color),
        .i_layer1_color       (i_layer1_color),
        .i_layer2_color       (i_layer2_color),
        .i_layer3_color       (i_layer3_color),
        .i_sprite_prio0_color (i_sprite_prio0_color),
        .i_sprite_prio1_color (i_sprite_prio1_color),
        .i_sprite_prio2_color (i_sprite_prio2_color),
        .i_sprite_prio3_color (i_sprite_prio3_color),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_screen_color       (o_screen_color)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predict the screen color of one pixel and advance the mosaic and line-store image
    function automatic logic [14:0] composite_pixel(input t_pixel px);
        int          blk_w;
        int          blk_h;
        int          n;
        int          p;
        logic        v_samp;
        logic        h_samp;
        logic        in_line;
        logic        found;
        t_color      c;
        t_color      lane [BGMC_LAYER_COUNT];
        logic [14:0] shown;
        blk_w   = int'(live_cfg.mos_w) + 1;
        blk_h   = int'(live_cfg.mos_h) + 1;
        v_samp  = (int'(px.line) % blk_h) == 0;
        h_samp  = (int'(px.column) % blk_w) == 0;
        in_line = int'(px.column) < BGMC_LINE_WIDTH;
        for (n = 0; n < BGMC_LAYER_COUNT; n++) begin
            c = px.bg[n];
            if (live_cfg.layer_en[n] && live_cfg.mos_en[n]) begin
                if (v_samp) begin
                    if (h_samp) held_colors[n] = c;
                    c = held_colors[n];
                end else begin
                    c = in_line ? line_store[n][px.column] : COLOR_CLEAR;
                end
            end
            if (in_line) line_store[n][px.column] = c;
            lane[n] = c;
        end
        // Walk priorities from zero: sprite first, then the lowest opaque layer index
        shown = live_cfg.backdrop;
        found = 1'b0;
        for (p = 0; p < BGMC_SPRITE_PRIOS && !found; p++) begin
            if (live_cfg.sprites && !px.spr[p][15]) begin
                shown = px.spr[p][14:0];
                found = 1'b1;
            end
            for (n = 0; n < BGMC_LAYER_COUNT && !found; n++) begin
                if (live_cfg.layer_en[n] && int'(live_cfg.prio[2*n +: 2]) == p &&
                    !lane[n][15]) begin
                    shown = lane[n][14:0];
                    found = 1'b1;
                end
            end
        end
        return shown;
    endfunction

    function automatic t_pixel pixel_of(input logic [7:0] line, input logic [7:0] column,
                                        input t_color b0, input t_color b1,
                                        input t_color b2, input t_color b3,
                                        input t_color s0, input t_color s1,
                                        input t_color s2, input t_color s3);
        t_pixel px;
        px.line   = line;
        px.column = column;
        px.bg     = {b3, b2, b1, b0};
        px.spr    = {s3, s2, s1, s0};
        return px;
    endfunction

    // Opaque about two times in three, any low bits either way
    function automatic t_color random_color();
        return {1'($urandom_range(0, 2) == 0), 15'($urandom)};
    endfunction

    function automatic t_pixel random_pixel(input logic [7:0] line, input logic [7:0] column);
        return pixel_of(line, column, random_color(), random_color(), random_color(),
                        random_color(), random_color(), random_color(), random_color(),
                        random_color());
    endfunction

    // Send one pixel word; valid is left high so the next word can follow back to back
    task automatic send_pixel(input t_pixel px);
        int unsigned gap;
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            gap = $urandom_range(1, 17);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_line_number        <= px.line;
        i_column             <= px.column;
        i_layer0_color       <= px.bg[0];
        i_layer1_color       <= px.bg[1];
        i_layer2_color       <= px.bg[2];
        i_layer3_color       <= px.bg[3];
        i_sprite_prio0_color <= px.spr[0];
        i_sprite_prio1_color <= px.spr[1];
        i_sprite_prio2_color <= px.spr[2];
        i_sprite_prio3_color <= px.spr[3];
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        pending_colors.push_back(composite_pixel(px));
    endtask

    // Write one register word and mirror it into the predictor
    task automatic write_reg(input t_cfg_idx idx, input logic [14:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_LAYER_ENABLE: live_cfg.layer_en = value[3:0];
            CFG_LAYER_PRIO:   live_cfg.prio     = value[7:0];
            CFG_SPRITES_ON:   live_cfg.sprites  = value[0];
            CFG_BACKDROP:     live_cfg.backdrop = value;
            CFG_MOSAIC_W:     live_cfg.mos_w    = value[3:0];
            CFG_MOSAIC_H:     live_cfg.mos_h    = value[3:0];
            CFG_LAYER_MOSAIC: live_cfg.mos_en   = value[3:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input t_regs r);
        write_reg(CFG_LAYER_ENABLE, 15'(r.layer_en));
        write_reg(CFG_LAYER_PRIO,   15'(r.prio));
        write_reg(CFG_SPRITES_ON,   15'(r.sprites));
        write_reg(CFG_BACKDROP,     r.backdrop);
        write_reg(CFG_MOSAIC_W,     15'(r.mos_w));
        write_reg(CFG_MOSAIC_H,     15'(r.mos_h));
        write_reg(CFG_LAYER_MOSAIC, 15'(r.mos_en));
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait until every predicted color has come out, plus pipeline depth
    task automatic drain_pixels();
        i_in_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Sprite versus background order across the four priority levels, backdrop fallback
    task automatic test_priority_order();
        t_regs r;
        r = '{layer_en: 4'hF, prio: 8'b00_01_10_11, sprites: 1'b1, backdrop: 15'h7FFF,
              mos_w: 4'd0, mos_h: 4'd0, mos_en: 4'h0};
        load_config(r);
        send_pixel(pixel_of(8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(pixel_of(8'd0, 8'd1, 16'h1111, 16'h2222, 16'h3333, 16'h4444,
                            16'h7FFF, 16'h0001, 16'h0002, 16'h0003));
        send_pixel(pixel_of(8'd0, 8'd2, 16'h1111, 16'h2222, 16'h3333, 16'h0000,
                            COLOR_CLEAR, 16'h0005, 16'h0006, 16'h0007));
        send_pixel(pixel_of(8'd0, 8'd3, 16'h1111, 16'h2222, 16'h3333, COLOR_CLEAR,
                            COLOR_CLEAR, 16'h1234, 16'h0006, 16'h0007));
        send_pixel(pixel_of(8'd0, 8'd4, 16'h7FFF, COLOR_CLEAR, COLOR_CLEAR, COLOR_CLEAR,
                            COLOR_CLEAR, COLOR_CLEAR, COLOR_CLEAR, COLOR_CLEAR));
        send_pixel(pixel_of(8'd0, 8'd5, 16'h0ABC, COLOR_CLEAR, COLOR_CLEAR, COLOR_CLEAR,
                            COLOR_CLEAR, COLOR_CLEAR, COLOR_CLEAR, 16'h5555));
        send_pixel(pixel_of(8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'h2AAA, 16'hFFFF,
                            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        drain_pixels();
    endtask

    // Equal priorities: lower layer index wins, disabled layers and sprites stay out
    task automatic test_equal_priority();
        t_regs r;
        r = '{layer_en: 4'b1110, prio: 8'h00, sprites: 1'b0, backdrop: 15'h0000,
              mos_w: 4'd0, mos_h: 4'd0, mos_en: 4'h0};
        load_config(r);
        send_pixel(pixel_of(8'd1, 8'd0, 16'h0101, 16'h0202, 16'h0303, 16'h0404,
                            16'h7777, 16'h7777, 16'h7777, 16'h7777));
        send_pixel(pixel_of(8'd1, 8'd1, 16'h0101, COLOR_CLEAR, 16'h0303, 16'h0404,
                            16'h7777, 16'h7777, 16'h7777, 16'h7777));
        send_pixel(pixel_of(8'd1, 8'd2, 16'h0101, COLOR_CLEAR, COLOR_CLEAR, COLOR_CLEAR,
                            COLOR_CLEAR, COLOR_CLEAR, COLOR_CLEAR, COLOR_CLEAR));
        send_pixel(pixel_of(8'd1, 8'd3, COLOR_CLEAR, COLOR_CLEAR, COLOR_CLEAR, COLOR_CLEAR,
                            16'h0001, 16'h0002, 16'h0003, 16'h0004));
        drain_pixels();
    endtask

    // Mosaic hold across columns, line-store repeat, columns past the line width,
    // mosaic bit on a disabled layer
    task automatic test_mosaic_edges();
        t_regs r;
        int    col;
        int    ln;
        r = '{layer_en: 4'b1101, prio: 8'b11_10_01_00, sprites: 1'b0, backdrop: 15'h2AAA,
              mos_w: 4'd2, mos_h: 4'd1, mos_en: 4'b0111};
        load_config(r);
        for (ln = 0; ln < 2; ln++) begin
            for (col = 0; col < 5; col++) begin
                send_pixel(pixel_of(8'(ln), 8'(col),
                                    (col == 3) ? COLOR_CLEAR : 16'(col * 16'h0843 + ln),
                                    16'(16'h0100 + col),
                                    16'(16'h0210 * (col + 1) + ln),
                                    16'h1F00, COLOR_CLEAR, COLOR_CLEAR, COLOR_CLEAR,
                                    COLOR_CLEAR));
            end
        end
        send_pixel(pixel_of(8'd1, 8'd240, 16'h0011, 16'h0022, 16'h0033, 16'h0044,
                            COLOR_CLEAR, COLOR_CLEAR, COLOR_CLEAR, COLOR_CLEAR));
        send_pixel(pixel_of(8'd1, 8'd255, 16'h0011, 16'h0022, 16'h0033, COLOR_CLEAR,
                            COLOR_CLEAR, COLOR_CLEAR, COLOR_CLEAR, COLOR_CLEAR));
        send_pixel(pixel_of(8'd2, 8'd0, 16'h7ABC, 16'h0022, 16'h0033, 16'h0044,
                            COLOR_CLEAR, COLOR_CLEAR, COLOR_CLEAR, COLOR_CLEAR));
        drain_pixels();
    endtask

    // Scanline runs with random content under changing settings, plus scattered noise
    task automatic test_random_frames();
        t_regs       r;
        int          ph;
        int          sent;
        int          k;
        int          run;
        logic [7:0]  first;
        logic [7:0]  line_no;
        for (ph = 0; ph < 8; ph++) begin
            if (ph == 0) begin
                r = '{layer_en: 4'hF, prio: 8'h00, sprites: 1'b0, backdrop: 15'h0000,
                      mos_w: 4'd0, mos_h: 4'd0, mos_en: 4'hF};
            end else if (ph == 1) begin
                r = '{layer_en: 4'hF, prio: 8'hFF, sprites: 1'b1, backdrop: 15'h7FFF,
                      mos_w: 4'd15, mos_h: 4'd15, mos_en: 4'hF};
            end else begin
                r.layer_en = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'hF;
                r.prio     = 8'($urandom);
                r.sprites  = 1'($urandom);
                r.backdrop = 15'($urandom);
                r.mos_w    = 4'($urandom);
                r.mos_h    = 4'($urandom_range(0, 5));
                r.mos_en   = 4'($urandom);
            end
            load_config(r);
            // Hold idling off in the last part, vary it elsewhere
            if (ph == 7) begin
                src_gap_pct = 0;
                sink_stalls = 1'b0;
            end else begin
                src_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
                sink_stalls = 1'($urandom);
            end
            sent    = 0;
            line_no = 8'd0;
            while (sent < 200) begin
                if ($urandom_range(0, 9) < 8) begin
                    first = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0;
                    run   = $urandom_range(1, 40);
                    for (k = 0; k < run && sent < 200; k++) begin
                        send_pixel(random_pixel(line_no, 8'(first + k)));
                        sent++;
                    end
                    line_no++;
                end else begin
                    send_pixel(random_pixel(8'($urandom), 8'($urandom)));
                    sent++;
                end
            end
            drain_pixels();
        end
    endtask

    // Sink side: random stall bursts while enabled
    always @(posedge i_clk) begin
        if (sink_stalls && hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 17) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each accepted result word with the oldest predicted color
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (pending_colors.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected screen word: got %h", o_screen_color);
                mismatch_count++;
            end else begin
                want = pending_colors.pop_front();
                if (o_screen_color !== want) begin
                    if (mismatch_count < 10)
                        $display("screen color mismatch: expected %h, got %h",
                                 want, o_screen_color);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run when no word moves on any channel for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready === 1'b1) ||
                (o_out_valid === 1'b1 && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial begin : main_seq
        int n;
        int col;
        live_cfg = '0;
        for (n = 0; n < BGMC_LAYER_COUNT; n++) begin
            held_colors[n] = COLOR_CLEAR;
            for (col = 0; col < BGMC_LINE_WIDTH; col++) line_store[n][col] = COLOR_CLEAR;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        src_gap_pct = 20;
        sink_stalls = 1'b1;
        test_priority_order();
        test_equal_priority();
        test_mosaic_edges();
        test_random_frames();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
